>>> hw/rtl/box_filter_3x3_mean_assert.svh
`ifndef BOX_FILTER_3X3_MEAN_ASSERT_SVH
`define BOX_FILTER_3X3_MEAN_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define BF3M_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define BF3M_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/bf3m_pkg.sv
`default_nettype none

package bf3m_pkg;

	// frame size limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int MIN_SIZE   = 3;

	localparam int PIX_W = 8;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	// clamped width and the lag counter hold values up to MAX_WIDTH + 1
	localparam int WN_W  = $clog2(MAX_WIDTH + 2);
	localparam int HN_W  = $clog2(MAX_HEIGHT + 1);

	// configuration registers
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

	// 3x3 window and its sum
	localparam int WIN_SIZE = 9;
	localparam int CENTER   = 4;
	localparam int SUM_W    = $clog2(WIN_SIZE * ((1 << PIX_W) - 1) + 1);

	// divide by 9 as multiply by ceil(2^15 / 9), exact for sums below 2^15
	localparam int DIV_MUL_W = 12;
	localparam logic [DIV_MUL_W-1:0] DIV_MUL = 12'd3641;
	localparam int DIV_SHIFT = 15;
	localparam int PROD_W    = SUM_W + DIV_MUL_W;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// one classified word on its way to the back end
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [PIX_W-1:0] sample;
		logic             has_res;
		logic             interior;
		logic             last;
	} item_t;

endpackage

`default_nettype wire

>>> hw/rtl/bf3m_if.sv
`default_nettype none

interface bf3m_raw_if;
	logic                        valid;
	logic                        ready;
	logic [bf3m_pkg::PIX_W-1:0]  pixel_in;
	logic                        flush;

	modport source (output valid, output pixel_in, output flush, input ready);
	modport sink (input valid, input pixel_in, input flush, output ready);
endinterface

interface bf3m_filt_if;
	logic                        valid;
	logic                        ready;
	logic [bf3m_pkg::PIX_W-1:0]  pixel_out;
	logic                        frame_end;

	modport source (output valid, output pixel_out, output frame_end, input ready);
	modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/box_filter_3x3_mean.sv
// 3x3 box mean filter on an 8-bit grayscale raster stream.
// raw: one word per pixel in raster order (pixel_in, flush); after the last pixel
//   of a frame the source sends image_width+1 words with flush set to drain it.
// filtered: one word per pixel in raster order (pixel_out, frame_end); interior
//   pixels carry the truncated mean of their 3x3 neighborhood, pixels of the
//   first and last row and column pass through; frame_end marks the last one.
// config: cfg_we writes cfg_data into register cfg_index (0 image_width,
//   1 image_height); write only while the filter is idle.
// a result belongs to the word image_width+1 places earlier in the stream;
//   the first image_width+1 words of a frame give no result.
// path: an accepted word reaches its result through the queue head, the line
//   store read, the window sum and the divide-by-9 multiply. throughput: one
//   word per clock while filtered is taken, set by the single read-modify-write
//   of the line stores per word.
// reset: counters clear, window clears, sizes go to 640x480; line store contents
//   are left as they are and never used before being written in a frame.
// stall: when filtered is not taken the back end holds; the four-entry queue
//   keeps taking raw words until it fills, then raw.ready drops.
`default_nettype none

module box_filter_3x3_mean (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [bf3m_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [bf3m_pkg::CFG_DATA_W-1:0]  cfg_data,
	bf3m_raw_if.sink                              raw,
	bf3m_filt_if.source                           filtered
);
	import bf3m_pkg::*;

	// front to queue
	item_t front_item;
	logic  push;
	logic  queue_full;
	// queue to back
	item_t head_item;
	logic  queue_avail;
	logic  pop;

	// counters, size registers and classification of each word
	bf3m_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.raw        (raw),
		.queue_full (queue_full),
		.push       (push),
		.item       (front_item)
	);

	// short queue so the front keeps taking words while the output stalls
	bf3m_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (pop),
		.head_item (head_item),
		.full      (queue_full),
		.avail     (queue_avail)
	);

	// line stores, window, sum, divide and output register
	bf3m_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.avail    (queue_avail),
		.item     (head_item),
		.pop      (pop),
		.filtered (filtered)
	);

endmodule

`default_nettype wire

>>> hw/rtl/bf3m_front.sv
`default_nettype none

module bf3m_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bf3m_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [bf3m_pkg::CFG_DATA_W-1:0]  cfg_data,
	bf3m_raw_if.sink                             raw,
	input  wire logic                            queue_full,
	output logic                                 push,
	output bf3m_pkg::item_t                      item
);
	import bf3m_pkg::*;

	function automatic logic [WN_W-1:0] clamp_width(input logic [WIDTH_REG_W-1:0] v);
		logic [WN_W-1:0] r;
		if (int'(v) < MIN_SIZE) r = WN_W'(MIN_SIZE);
		else if (int'(v) > MAX_WIDTH) r = WN_W'(MAX_WIDTH);
		else r = WN_W'(v);
		return r;
	endfunction

	function automatic logic [HN_W-1:0] clamp_height(input logic [HEIGHT_REG_W-1:0] v);
		logic [HN_W-1:0] r;
		if (int'(v) < MIN_SIZE) r = HN_W'(MIN_SIZE);
		else if (int'(v) > MAX_HEIGHT) r = HN_W'(MAX_HEIGHT);
		else r = HN_W'(v);
		return r;
	endfunction

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [COL_W-1:0]        in_col_q;
	logic [COL_W-1:0]        out_col_q;
	logic [ROW_W-1:0]        out_row_q;
	logic [WN_W-1:0]         lag_q;

	logic [WN_W-1:0] w;
	logic [HN_W-1:0] h;
	logic [WN_W-1:0] in_col_inc;
	logic [WN_W-1:0] out_col_inc;
	logic [HN_W-1:0] out_row_inc;
	logic            has_res;
	logic            last_col;
	logic            last;
	logic            interior;

	assign raw.ready = !queue_full;
	assign push      = raw.valid && !queue_full;

	always_comb begin
		w           = clamp_width(width_q);
		h           = clamp_height(height_q);
		in_col_inc  = WN_W'(in_col_q) + WN_W'(1);
		out_col_inc = WN_W'(out_col_q) + WN_W'(1);
		out_row_inc = HN_W'(out_row_q) + HN_W'(1);
		// results start once the window has moved one row and one column past
		has_res     = lag_q >= (w + WN_W'(1));
		last_col    = out_col_inc >= w;
		last        = last_col && (out_row_inc >= h);
		interior    = (out_row_q != '0) && (out_row_inc < h) &&
		              (out_col_q != '0) && (out_col_inc < w);
	end

	always_comb begin
		item.col      = in_col_q;
		item.sample   = raw.flush ? '0 : raw.pixel_in;
		item.has_res  = has_res;
		item.interior = interior;
		item.last     = has_res && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			lag_q     <= '0;
		end else if (push) begin
			// input column wraps at the width, and restarts when the frame ends
			in_col_q <= ((has_res && last) || (in_col_inc >= w)) ? '0 :
			            in_col_inc[COL_W-1:0];
			priority if (!has_res) begin
				lag_q <= lag_q + WN_W'(1);
			end else if (last) begin
				// frame done, everything starts over
				out_col_q <= '0;
				out_row_q <= '0;
				lag_q     <= '0;
			end else if (last_col) begin
				out_col_q <= '0;
				out_row_q <= out_row_q + ROW_W'(1);
			end else begin
				out_col_q <= out_col_inc[COL_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/bf3m_queue.sv
`default_nettype none

module bf3m_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire bf3m_pkg::item_t push_item,
	input  wire logic            pop,
	output bf3m_pkg::item_t      head_item,
	output logic                 full,
	output logic                 avail
);
	import bf3m_pkg::*;

	item_t               entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign full      = count_q == QCNT_W'(QUEUE_DEPTH);
	assign avail     = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && avail;
	assign head_item = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) entries_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) count_q <= count_q + QCNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/bf3m_back.sv
`default_nettype none

module bf3m_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            avail,
	input  wire bf3m_pkg::item_t item,
	output logic                 pop,
	bf3m_filt_if.source          filtered
);
	import bf3m_pkg::*;

	// line stores, read when a word enters s1, written when it leaves
	logic [PIX_W-1:0] line_store_upper [MAX_WIDTH];
	logic [PIX_W-1:0] line_store_lower [MAX_WIDTH];

	logic             valid_s1;
	item_t            item_s1;
	logic [PIX_W-1:0] upper_rd_s1;
	logic [PIX_W-1:0] lower_rd_s1;
	logic             fwd_s1;
	logic [PIX_W-1:0] fwd_upper_s1;
	logic [PIX_W-1:0] fwd_lower_s1;

	logic [PIX_W-1:0] win_q [WIN_SIZE];

	logic             valid_s2;
	logic             interior_s2;
	logic             last_s2;

	logic             valid_s3;
	logic             interior_s3;
	logic             last_s3;
	logic [SUM_W-1:0] sum_s3;
	logic [PIX_W-1:0] center_s3;

	logic             out_valid_q;
	logic [PIX_W-1:0] pixel_q;
	logic             frame_end_q;

	logic              adv;
	logic              wr_en;
	logic [PIX_W-1:0]  upper_eff;
	logic [PIX_W-1:0]  lower_eff;
	logic [SUM_W-1:0]  win_sum;
	logic [PROD_W-1:0] prod;
	logic [PIX_W-1:0]  quot;

	assign adv   = !out_valid_q || filtered.ready;
	assign pop   = adv && avail;
	assign wr_en = adv && valid_s1;

	assign filtered.valid     = out_valid_q;
	assign filtered.pixel_out = pixel_q;
	assign filtered.frame_end = frame_end_q;

	// the word leaving s1 may write the entry the new word just read
	assign upper_eff = fwd_s1 ? fwd_upper_s1 : upper_rd_s1;
	assign lower_eff = fwd_s1 ? fwd_lower_s1 : lower_rd_s1;

	always_ff @(posedge clk) begin
		if (pop) begin
			upper_rd_s1  <= line_store_upper[item.col];
			lower_rd_s1  <= line_store_lower[item.col];
			fwd_s1       <= wr_en && (item_s1.col == item.col);
			fwd_upper_s1 <= lower_eff;
			fwd_lower_s1 <= item_s1.sample;
			item_s1      <= item;
		end
		if (wr_en) begin
			line_store_upper[item_s1.col] <= lower_eff;
			line_store_lower[item_s1.col] <= item_s1.sample;
		end
	end

	always_comb begin
		win_sum = '0;
		for (int k = 0; k < WIN_SIZE; k++) begin
			win_sum = win_sum + SUM_W'(win_q[k]);
		end
	end

	assign prod = PROD_W'(sum_s3) * PROD_W'(DIV_MUL);
	assign quot = prod[DIV_SHIFT +: PIX_W];

	// window shifts left once per word, new right column from the stores and the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN_SIZE; k++) win_q[k] <= '0;
		end else if (wr_en) begin
			for (int k = 0; k < WIN_SIZE - 3; k++) win_q[k] <= win_q[k + 3];
			win_q[WIN_SIZE - 3] <= upper_eff;
			win_q[WIN_SIZE - 2] <= lower_eff;
			win_q[WIN_SIZE - 1] <= item_s1.sample;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			interior_s2 <= item_s1.interior;
			last_s2     <= item_s1.last;
			interior_s3 <= interior_s2;
			last_s3     <= last_s2;
			sum_s3      <= win_sum;
			center_s3   <= win_q[CENTER];
			pixel_q     <= interior_s3 ? quot : center_s3;
			frame_end_q <= last_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= avail;
			valid_s2    <= valid_s1 && item_s1.has_res;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/bf3m_checker.sv
`default_nettype none

`include "box_filter_3x3_mean_assert.svh"

module bf3m_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       raw_ready,
	input wire logic                       filtered_valid,
	input wire logic                       filtered_ready,
	input wire logic [bf3m_pkg::PIX_W-1:0] filtered_pixel_out,
	input wire logic                       filtered_frame_end
);

	// a stalled output word holds
	`BF3M_ASSERT_NXT(a_out_hold, clk, arst_n, filtered_valid && !filtered_ready, filtered_valid && $stable(filtered_pixel_out) && $stable(filtered_frame_end), "filtered word changed while stalled")

	// nothing on the output right after reset
	`BF3M_ASSERT_IMP(a_out_idle_after_reset, clk, arst_n, $rose(arst_n), !filtered_valid, "filtered valid right after reset")

	// the queue frees an entry whenever the output side moves
	`BF3M_ASSERT_NXT(a_ready_after_move, clk, arst_n, !filtered_valid || filtered_ready, raw_ready, "raw not ready although the back end moved")

	// a new frame needs at least four words before its first result
	`BF3M_ASSERT_NXT(a_gap_after_frame, clk, arst_n, filtered_valid && filtered_ready && filtered_frame_end, !filtered_valid ##1 !filtered_valid ##1 !filtered_valid, "result too soon after frame end")

endmodule

bind box_filter_3x3_mean bf3m_checker u_bf3m_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.raw_ready          (raw.ready),
	.filtered_valid     (filtered.valid),
	.filtered_ready     (filtered.ready),
	.filtered_pixel_out (filtered.pixel_out),
	.filtered_frame_end (filtered.frame_end)
);

`default_nettype wire
